// ----- hw/rtl/sc2a_pkg.sv -----
// Package with shared types, event codes and key tables for the scancode line editor.
`timescale 1ns / 1ps

package sc2a_pkg;

    localparam int LINE_CHARS_DEFAULT = 62;
    localparam int COUNT_W            = 6;
    localparam int CHAR_W             = 7;
    localparam int SCAN_W             = 8;

    localparam logic [SCAN_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [SCAN_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [SCAN_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [SCAN_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [SCAN_W-1:0] SC_CAPS_MAKE    = 8'h3A;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_CASE_BIT  = 7'h20;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_APPEND   = 2'd1,
        EV_ERASE    = 2'd2,
        EV_LINE_END = 2'd3
    } event_t;

    typedef struct packed {
        logic                  shift_held;
        logic                  caps_on;
        logic [CHAR_W-1:0]     previous_make;
        logic [COUNT_W-1:0]    chars_in_line;
    } edit_state_t;

    typedef struct packed {
        event_t                event_res;
        logic [CHAR_W-1:0]     character;
        logic [COUNT_W-1:0]    line_length;
    } edit_result_t;

    // Unshifted key map; codes outside the table give zero.
    function automatic logic [CHAR_W-1:0] plain_char(input logic [CHAR_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = '0;
        case (idx)
            7'd1:  c = 7'h1B;
            7'd2:  c = 7'h31;
            7'd3:  c = 7'h32;
            7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;
            7'd6:  c = 7'h35;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;
            7'd10: c = 7'h39;
            7'd11: c = 7'h30;
            7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;
            7'd14: c = 7'h08;
            7'd15: c = 7'h09;
            7'd16: c = 7'h71;
            7'd17: c = 7'h77;
            7'd18: c = 7'h65;
            7'd19: c = 7'h72;
            7'd20: c = 7'h74;
            7'd21: c = 7'h79;
            7'd22: c = 7'h75;
            7'd23: c = 7'h69;
            7'd24: c = 7'h6F;
            7'd25: c = 7'h70;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h61;
            7'd31: c = 7'h73;
            7'd32: c = 7'h64;
            7'd33: c = 7'h66;
            7'd34: c = 7'h67;
            7'd35: c = 7'h68;
            7'd36: c = 7'h6A;
            7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'h27;
            7'd41: c = 7'h60;
            7'd43: c = 7'h5C;
            7'd44: c = 7'h7A;
            7'd45: c = 7'h78;
            7'd46: c = 7'h63;
            7'd47: c = 7'h76;
            7'd48: c = 7'h62;
            7'd49: c = 7'h6E;
            7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;
            7'd52: c = 7'h2E;
            7'd53: c = 7'h2F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Shifted key map. Note that the shifted 6 key stays '6'.
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [CHAR_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = '0;
        case (idx)
            7'd1:  c = 7'h1B;
            7'd2:  c = 7'h21;
            7'd3:  c = 7'h40;
            7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;
            7'd6:  c = 7'h25;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h26;
            7'd9:  c = 7'h2A;
            7'd10: c = 7'h28;
            7'd11: c = 7'h29;
            7'd12: c = 7'h5F;
            7'd13: c = 7'h2B;
            7'd14: c = 7'h08;
            7'd15: c = 7'h09;
            7'd16: c = 7'h51;
            7'd17: c = 7'h57;
            7'd18: c = 7'h45;
            7'd19: c = 7'h52;
            7'd20: c = 7'h54;
            7'd21: c = 7'h59;
            7'd22: c = 7'h55;
            7'd23: c = 7'h49;
            7'd24: c = 7'h4F;
            7'd25: c = 7'h50;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h41;
            7'd31: c = 7'h53;
            7'd32: c = 7'h44;
            7'd33: c = 7'h46;
            7'd34: c = 7'h47;
            7'd35: c = 7'h48;
            7'd36: c = 7'h4A;
            7'd37: c = 7'h4B;
            7'd38: c = 7'h4C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'h27;
            7'd41: c = 7'h60;
            7'd43: c = 7'h5C;
            7'd44: c = 7'h5A;
            7'd45: c = 7'h58;
            7'd46: c = 7'h43;
            7'd47: c = 7'h56;
            7'd48: c = 7'h42;
            7'd49: c = 7'h4E;
            7'd50: c = 7'h4D;
            7'd51: c = 7'h3C;
            7'd52: c = 7'h3E;
            7'd53: c = 7'h2F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Caps-lock map: the plain map with letters in upper case.
    function automatic logic [CHAR_W-1:0] caps_char(input logic [CHAR_W-1:0] idx);
        logic [CHAR_W-1:0] p;
        p = plain_char(idx);
        if (p >= CH_LOWER_A && p <= CH_LOWER_Z)
        begin
            p = p & ~CH_CASE_BIT;
        end
        return p;
    endfunction

endpackage

// ----- hw/rtl/sc2a_edit.sv -----
// Combinational step of the line editor: key tracking, mapping and line count update.
`timescale 1ns / 1ps

module sc2a_edit
    import sc2a_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEFAULT
)
(
    input  logic [SCAN_W-1:0] scancode,
    input  edit_state_t       state,
    output edit_state_t       state_next,
    output edit_result_t      result
);

    // The count register holds at most 63, so larger limits clamp there.
    localparam int LimitInt = (LINE_CHARS > (2**COUNT_W - 1)) ? (2**COUNT_W - 1) : LINE_CHARS;
    localparam logic [COUNT_W-1:0] LineLimit = COUNT_W'(LimitInt);

    logic                 shift_next;
    logic                 caps_next;
    logic                 new_make;
    logic [CHAR_W-1:0]    idx;
    logic [CHAR_W-1:0]    plain_c;
    logic [CHAR_W-1:0]    mapped;
    logic                 plain_lower;
    logic [COUNT_W-1:0]   count_edit;
    event_t               ev;
    logic [CHAR_W-1:0]    ch_out;

    assign idx = scancode[CHAR_W-1:0];

    always_comb
    begin
        shift_next = state.shift_held;
        if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE)
        begin
            shift_next = 1'b1;
        end
        else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK)
        begin
            shift_next = 1'b0;
        end
    end

    assign caps_next   = state.caps_on ^ (scancode == SC_CAPS_MAKE);
    assign new_make    = !scancode[SCAN_W-1] && (idx != state.previous_make);
    assign plain_c     = plain_char(idx);
    assign plain_lower = (plain_c >= CH_LOWER_A) && (plain_c <= CH_LOWER_Z);

    always_comb
    begin
        if (shift_next)
        begin
            mapped = shifted_char(idx);
        end
        else if (caps_next && plain_lower)
        begin
            mapped = caps_char(idx);
        end
        else
        begin
            mapped = plain_c;
        end
    end

    always_comb
    begin
        ev         = EV_NONE;
        ch_out     = '0;
        count_edit = state.chars_in_line;
        if (new_make && mapped != '0)
        begin
            if (mapped == CH_NEWLINE)
            begin
                ev = EV_LINE_END;
            end
            else if (mapped == CH_BACKSPACE)
            begin
                if (state.chars_in_line != '0)
                begin
                    ev         = EV_ERASE;
                    count_edit = state.chars_in_line - COUNT_W'(1);
                end
            end
            else if (state.chars_in_line < LineLimit)
            begin
                ev         = EV_APPEND;
                ch_out     = mapped;
                count_edit = state.chars_in_line + COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next.shift_held    = shift_next;
        state_next.caps_on       = caps_next;
        state_next.chars_in_line = (ev == EV_LINE_END) ? '0 : count_edit;
        if (new_make)
        begin
            state_next.previous_make = idx;
        end
        else if (scancode[SCAN_W-1])
        begin
            state_next.previous_make = '0;
        end
        else
        begin
            state_next.previous_make = state.previous_make;
        end
        result.event_res   = ev;
        result.character   = ch_out;
        result.line_length = count_edit;
    end

endmodule

// ----- hw/rtl/scancode_to_ascii_line_editor.sv -----
// Top level of the set-1 scancode to ASCII line editor with stream ports.
`timescale 1ns / 1ps

// The block takes one raw set-1 keyboard scancode per input transfer and
// gives exactly one result transfer for each. It tracks the two shift keys
// and the caps-lock toggle, drops repeated make codes until any break code
// arrives, maps each new make code to ASCII, and keeps the length of a line
// of up to LINE_CHARS characters (clamped to 63). The result's tuser field
// tells what happened: nothing, a character appended, the last character
// erased, or the line ended; on line end the finished length is reported
// and the count starts again from zero. The scancode is captured in an input
// register, the whole step (table lookup, flag update, count add or
// subtract) is one short stage of logic, and the result lands in an output
// register. A new scancode is taken in every cycle while results are being
// drained, so the sustained rate is one item per clock. The result becomes
// valid when the item passes from the input register into the output
// register. Stalls on the result side hold both registers; the editor
// state only moves when an item passes from the input register into the
// output register.
module scancode_to_ascii_line_editor
    import sc2a_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] character, [12:7] line_length, [15:13] zero
    output logic [1:0]  m_tuser    // [1:0] event_res
);

    logic              in_valid_reg;
    logic [SCAN_W-1:0] in_scan_reg;
    logic              out_valid_reg;
    edit_result_t      out_result_reg;
    edit_state_t       state_reg;
    edit_state_t       state_next;
    edit_result_t      result_next;
    logic              out_free;
    logic              advance;

    // The output register can take a new result when it is empty or being
    // read in this cycle; the input register moves forward at the same time.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_scan_reg <= s_tdata;
        end
    end

    sc2a_edit #(
        .LINE_CHARS (LINE_CHARS)
    ) u_edit (
        .scancode   (in_scan_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Keyboard state and line count advance once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.line_length, out_result_reg.character};
    assign m_tuser  = out_result_reg.event_res;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the scancode to ASCII line editor.
`timescale 1ns / 1ps

// The bench drives raw set-1 scancodes into the slave stream and checks every
// result transfer on the master stream against a predictor kept inside this
// module. The predictor has its own key maps and its own copy of the editor
// state. It is stepped once for each scancode the block accepts, and it pushes
// the result it expects onto a queue. The monitor pops that queue once for
// each result transfer.
//
// Stimulus comes in two parts. First a short directed table covers the field
// extremes, the shift and caps-lock keys, key repeat, escape and tab, erase on
// an empty line, and line end. Where a row's result is obvious, the row holds
// the expected result. Then a random part follows, made of planned sequences:
// mostly well-formed typing, some lines typed up to or past the length
// limit, and some noise and broken key sequences. Handshake pressure
// changes from phase to phase.
module tb;

    import sc2a_pkg::*;

    localparam int          CLK_HALF_NS      = 4;
    localparam int          RESET_CYCLES     = 11;
    localparam int          RANDOM_SCANS     = 825;
    localparam int          DIRECTED_ROWS    = 25;
    localparam int          LONG_HOLD_CYCLES = 150;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          MAX_REPORTS      = 10;
    localparam int          LINE_LIMIT       =
        (LINE_CHARS_DEFAULT > 63) ? 63 : LINE_CHARS_DEFAULT;

    // Key numbers (a make code without its break bit) that the editor treats specially.
    localparam logic [6:0]  KEY_BACKSPACE    = 7'h0E;
    localparam logic [6:0]  KEY_ENTER        = 7'h1C;
    localparam logic [7:0]  BREAK_BIT        = 8'h80;

    typedef struct packed {
        logic [7:0]  code;
        logic        typed;
        event_t      ev;
        logic [6:0]  ch;
        logic [5:0]  len;
    } scan_row_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic [1:0]   m_tuser;

    // Predictor state, which mirrors the editor registers.
    logic         kb_shift   = 1'b0;
    logic         kb_caps    = 1'b0;
    logic [6:0]   last_make  = '0;
    logic [5:0]   line_count = '0;
    logic [6:0]   plain_keys   [0:127];
    logic [6:0]   shifted_keys [0:127];

    edit_result_t expected_edits [$];
    edit_result_t oldest_edit;
    logic [7:0]   planned_scans [$];

    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_requests  = 0;
    int           hold_served    = 0;
    int           hold_left      = 0;
    int           scans_sent     = 0;
    int           fault_count    = 0;
    int           cycle_count    = 0;

    // In the directed table, rows with typed set to one carry their expected
    // result. The predictor supplies the result for all other rows.
    scan_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{8'h0E, 1'b1, EV_NONE,     7'h00, 6'd0},  // erase on an empty line
        '{8'h00, 1'b1, EV_NONE,     7'h00, 6'd0},  // lowest code, maps to nothing
        '{8'h00, 1'b1, EV_NONE,     7'h00, 6'd0},  // the same code again is a repeat
        '{8'hFF, 1'b1, EV_NONE,     7'h00, 6'd0},  // highest break code
        '{8'h7F, 1'b1, EV_NONE,     7'h00, 6'd0},  // highest make code, unmapped
        '{8'h1E, 1'b1, EV_APPEND,   7'h61, 6'd1},  // plain 'a'
        '{8'h1E, 1'b1, EV_NONE,     7'h00, 6'd1},  // key repeat is dropped
        '{8'h9E, 1'b1, EV_NONE,     7'h00, 6'd1},  // break re-arms the repeat filter
        '{8'h3A, 1'b0, EV_NONE,     7'h00, 6'd0},  // caps-lock on
        '{8'h1E, 1'b0, EV_NONE,     7'h00, 6'd0},  // caps letter
        '{8'h3A, 1'b0, EV_NONE,     7'h00, 6'd0},  // caps-lock off
        '{8'h3A, 1'b0, EV_NONE,     7'h00, 6'd0},  // repeated caps-lock still toggles
        '{8'h2A, 1'b0, EV_NONE,     7'h00, 6'd0},  // left shift make
        '{8'h02, 1'b0, EV_NONE,     7'h00, 6'd0},  // shifted digit
        '{8'h07, 1'b0, EV_NONE,     7'h00, 6'd0},  // shifted six stays a six
        '{8'hAA, 1'b0, EV_NONE,     7'h00, 6'd0},  // left shift break
        '{8'h36, 1'b0, EV_NONE,     7'h00, 6'd0},  // right shift make
        '{8'h10, 1'b0, EV_NONE,     7'h00, 6'd0},  // shift wins over caps-lock
        '{8'hB6, 1'b0, EV_NONE,     7'h00, 6'd0},  // right shift break
        '{8'h01, 1'b0, EV_NONE,     7'h00, 6'd0},  // escape is appended
        '{8'h0F, 1'b0, EV_NONE,     7'h00, 6'd0},  // tab is appended
        '{8'h0E, 1'b0, EV_NONE,     7'h00, 6'd0},  // erase the tab
        '{8'h1C, 1'b0, EV_NONE,     7'h00, 6'd0},  // line end with its length
        '{8'h1C, 1'b1, EV_NONE,     7'h00, 6'd0},  // repeated enter is dropped
        '{8'h80, 1'b1, EV_NONE,     7'h00, 6'd0}   // lowest break code
    };

    scancode_to_ascii_line_editor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // Copy a run of printable characters into one of the two key maps.
    task automatic put_keys(input int first, input string text, input bit shifted);
        int  i;
        byte b;
        for (i = 0; i < text.len(); i++)
        begin
            b = text[i];
            if (shifted)
            begin
                shifted_keys[first + i] = b[6:0];
            end
            else
            begin
                plain_keys[first + i] = b[6:0];
            end
        end
    endtask

    task automatic load_key_maps();
        int i;
        for (i = 0; i < 128; i++)
        begin
            plain_keys[i] = '0;
        end
        plain_keys[1]  = 7'h1B;          // escape
        plain_keys[14] = CH_BACKSPACE;
        plain_keys[15] = 7'h09;          // tab
        plain_keys[28] = CH_NEWLINE;
        plain_keys[40] = 7'h27;          // apostrophe
        plain_keys[41] = 7'h60;          // grave accent
        plain_keys[43] = 7'h5C;          // backslash
        plain_keys[55] = 7'h2A;          // keypad star
        plain_keys[57] = 7'h20;          // space
        put_keys(2,  "1234567890-=", 1'b0);
        put_keys(16, "qwertyuiop[]", 1'b0);
        put_keys(30, "asdfghjkl;",   1'b0);
        put_keys(44, "zxcvbnm,./",   1'b0);
        // The shifted map differs from the plain map only on the digit, letter
        // and bottom-row keys.
        for (i = 0; i < 128; i++)
        begin
            shifted_keys[i] = plain_keys[i];
        end
        put_keys(2,  "!@#$%6&*()_+", 1'b1);
        put_keys(16, "QWERTYUIOP[]", 1'b1);
        put_keys(30, "ASDFGHJKL;",   1'b1);
        put_keys(44, "ZXCVBNM<>/",   1'b1);
    endtask

    // Step the editor state by one scancode and return the result it causes.
    function automatic edit_result_t apply_scancode(input logic [7:0] code);
        edit_result_t r;
        logic [6:0]   key;
        logic [6:0]   c;
        r.event_res = EV_NONE;
        r.character = '0;
        key = code[6:0];
        if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE)
        begin
            kb_shift = 1'b1;
        end
        if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK)
        begin
            kb_shift = 1'b0;
        end
        if (code == SC_CAPS_MAKE)
        begin
            kb_caps = !kb_caps;
        end
        if (!code[7] && key != last_make)
        begin
            c = plain_keys[key];
            // Caps-lock only upper-cases letters, and shift overrides it.
            if (kb_caps && c >= CH_LOWER_A && c <= CH_LOWER_Z)
            begin
                c = c - CH_CASE_BIT;
            end
            if (kb_shift)
            begin
                c = shifted_keys[key];
            end
            if (c == CH_NEWLINE)
            begin
                r.event_res = EV_LINE_END;
            end
            else if (c == CH_BACKSPACE)
            begin
                if (line_count != 0)
                begin
                    line_count  = line_count - 1'b1;
                    r.event_res = EV_ERASE;
                end
            end
            else if (c != 0 && line_count < LINE_LIMIT)
            begin
                line_count  = line_count + 1'b1;
                r.event_res = EV_APPEND;
                r.character = c;
            end
            last_make = key;
        end
        else if (code[7])
        begin
            last_make = '0;
        end
        r.line_length = line_count;
        if (r.event_res == EV_LINE_END)
        begin
            line_count = '0;
        end
        return r;
    endfunction

    // Offer one scancode, with random idle cycles first, and hold it until
    // the transfer completes. When the transfer completes, the expected
    // result is queued: the typed one if the row has it, else the predicted one.
    task automatic send_scan(input logic [7:0] code, input bit typed, input edit_result_t want);
        edit_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = apply_scancode(code);
        expected_edits.push_back(typed ? want : predicted);
        scans_sent++;
    endtask

    // Hold the sender off until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_edits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Plan the next stretch of random stimulus onto planned_scans.
    task automatic plan_sequence(input bit full_line);
        int          kind;
        int          count;
        int          k;
        int          roll;
        bit          shifted;
        logic [6:0]  key;
        logic [7:0]  code;
        kind = full_line ? 0 : $urandom_range(99);
        if (kind < 5)
        begin
            // Type letters up to or past the line limit, then end the line.
            count = $urandom_range(LINE_LIMIT, LINE_LIMIT + 4);
            for (k = 0; k < count; k++)
            begin
                key = 7'($urandom_range(16, 25));
                planned_scans.push_back({1'b0, key});
                planned_scans.push_back({1'b1, key});
            end
            planned_scans.push_back({1'b0, KEY_ENTER});
            planned_scans.push_back({1'b1, KEY_ENTER});
        end
        else if (kind < 65)
        begin
            // Ordinary typing: make and break pairs, with shift, caps-lock,
            // erases, line ends and the odd key repeat.
            count = $urandom_range(3, 20);
            for (k = 0; k < count; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                begin
                    key = KEY_BACKSPACE;
                end
                else if (roll < 15)
                begin
                    key = KEY_ENTER;
                end
                else
                begin
                    key = 7'($urandom_range(1, 57));
                end
                shifted = ($urandom_range(9) == 0);
                if (shifted)
                begin
                    planned_scans.push_back($urandom_range(1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
                end
                if ($urandom_range(19) == 0)
                begin
                    planned_scans.push_back(SC_CAPS_MAKE);
                    planned_scans.push_back(SC_CAPS_MAKE | BREAK_BIT);
                end
                planned_scans.push_back({1'b0, key});
                if ($urandom_range(4) == 0)
                begin
                    planned_scans.push_back({1'b0, key});
                end
                if ($urandom_range(9) != 0)
                begin
                    planned_scans.push_back({1'b1, key});
                end
                if (shifted)
                begin
                    planned_scans.push_back($urandom_range(1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
                end
            end
        end
        else if (kind < 80)
        begin
            // Noise: any byte at all.
            count = $urandom_range(1, 10);
            for (k = 0; k < count; k++)
            begin
                code = 8'($urandom_range(255));
                planned_scans.push_back(code);
            end
        end
        else
        begin
            // Broken sequences: makes with no breaks, shift and caps-lock churn.
            count = $urandom_range(4, 16);
            for (k = 0; k < count; k++)
            begin
                key = 7'($urandom_range(1, 57));
                case ($urandom_range(7))
                    0:       code = SC_LSHIFT_MAKE;
                    1:       code = SC_RSHIFT_MAKE;
                    2:       code = SC_LSHIFT_BREAK;
                    3:       code = SC_RSHIFT_BREAK;
                    4:       code = SC_CAPS_MAKE;
                    5:       code = {1'b0, KEY_BACKSPACE};
                    6:       code = {1'b0, KEY_ENTER};
                    default: code = {1'b0, key};
                endcase
                planned_scans.push_back(code);
            end
        end
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // The receiver stalls at random. On request it instead holds tready low
    // for a long stretch, counted here, so that the block backs up and stops
    // accepting input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each result transfer is compared, field by field, with the oldest
    // expected result. The pad bits above the length must be zero.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_edits.size() == 0)
            begin
                note_fault($sformatf(
                    "result with nothing expected: event %0d char %02h len %0d",
                    m_tuser, m_tdata[6:0], m_tdata[12:7]));
            end
            else
            begin
                oldest_edit = expected_edits.pop_front();
                if (m_tuser !== oldest_edit.event_res || m_tdata[6:0] !== oldest_edit.character
                    || m_tdata[12:7] !== oldest_edit.line_length || m_tdata[15:13] !== 3'b000)
                begin
                    note_fault($sformatf(
                        {"got event %0d char %02h len %0d pad %0d, ",
                         "expected event %0d char %02h len %0d"},
                        m_tuser, m_tdata[6:0], m_tdata[12:7], m_tdata[15:13],
                        oldest_edit.event_res, oldest_edit.character, oldest_edit.line_length));
                end
            end
        end
    end

    // Watchdog for a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int           phase;
        int           row;
        edit_result_t typed_edit;
        load_key_maps();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, with no idling on either side.
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            typed_edit.event_res   = directed_rows[row].ev;
            typed_edit.character   = directed_rows[row].ch;
            typed_edit.line_length = directed_rows[row].len;
            send_scan(directed_rows[row].code, directed_rows[row].typed, typed_edit);
        end
        drain_results();

        // Random part in four phases: no idling, an idle sender, a stalling
        // receiver, then both. Each phase ends with the sender held off until
        // every result is back. The long receiver hold falls in the first and
        // last phases.
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 32 : 0;
            recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 32 : 0;
            if (phase == 0 || phase == 3)
            begin
                hold_requests++;
            end
            if (phase == 0 || phase == 2)
            begin
                plan_sequence(1'b1);
            end
            while (scans_sent < DIRECTED_ROWS + (phase + 1) * RANDOM_SCANS / 4)
            begin
                if (planned_scans.size() == 0)
                begin
                    plan_sequence(1'b0);
                end
                send_scan(planned_scans.pop_front(), 1'b0, typed_edit);
            end
            planned_scans.delete();
            drain_results();
        end

        // Leave room for any stray result to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
